// ----- rtl/dth_pkg.sv -----
// dth_pkg: shared constants, CORDIC arctangent table and side-band types
// for the tangent-heading pipeline. No dependencies.
package dth_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SC_LAT       = CORDIC_STEPS + 2;
    localparam int SQ_STEPS     = 32;
    localparam int NORM_STEPS   = 5;
    localparam int VEC_LAT      = CORDIC_STEPS + NORM_STEPS + 2;

    localparam logic [30:0]        RADIUS_RESET = 31'd98304;
    localparam logic signed [32:0] CORDIC_K     = 33'sd652032874;
    localparam logic [31:0]        QTURN        = 32'h4000_0000;

    // atan(2^-i) in 32-bit turn units
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic               valid;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [15:0]        th;
    } t_sc_side;

    typedef struct packed {
        logic               valid;
        logic               reach;
        logic               right;
        logic               left;
        logic [15:0]        th;
        logic signed [32:0] pxk;
        logic signed [32:0] pyk;
        logic [30:0]        rk;
    } t_sq_side;

    typedef struct packed {
        logic        valid;
        logic        reach;
        logic        right;
        logic        left;
        logic [15:0] th;
        logic        szero;
    } t_vec_side;

endpackage

// ----- rtl/dth_sincos.sv -----
// dth_sincos: pipelined CORDIC rotation, sin/cos of a 16-bit binary angle
// in Q2.30, one iteration per stage. Uses dth_pkg.
module dth_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_heading,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    localparam int N = dth_pkg::CORDIC_STEPS;

    logic signed [32:0] r_x [N+1];
    logic signed [32:0] r_y [N+1];
    logic signed [33:0] r_z [N+1];
    logic               r_flip [N+1];
    logic signed [31:0] r_cos, r_sin;

    logic signed [33:0] z0, n_z;
    logic               n_flip;
    logic signed [32:0] cx, cy;
    logic signed [31:0] n_cos, n_sin;

    always_comb begin
        z0 = {{2{i_heading[15]}}, i_heading, 16'h0000};
        n_z = z0;
        n_flip = 1'b0;
        if (z0 > 34'sh0_4000_0000) begin
            n_z = z0 - 34'sh0_8000_0000;
            n_flip = 1'b1;
        end else if (z0 < -34'sh0_4000_0000) begin
            n_z = z0 + 34'sh0_8000_0000;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= dth_pkg::CORDIC_K;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({2'b00, dth_pkg::ATAN_TAB[i]});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({2'b00, dth_pkg::ATAN_TAB[i]});
                end
            end
        end
    end

    // clamp to [-1,1] then undo the half-turn fold
    always_comb begin
        cx = r_x[N];
        cy = r_y[N];
        if (cx > 33'sh0_4000_0000)  cx = 33'sh0_4000_0000;
        if (cx < -33'sh0_4000_0000) cx = -33'sh0_4000_0000;
        if (cy > 33'sh0_4000_0000)  cy = 33'sh0_4000_0000;
        if (cy < -33'sh0_4000_0000) cy = -33'sh0_4000_0000;
        if (r_flip[N]) begin
            cx = -cx;
            cy = -cy;
        end
        n_cos = cx[31:0];
        n_sin = cy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// ----- rtl/dth_isqrt.sv -----
// dth_isqrt: pipelined integer square root, one result bit per stage.
// Uses dth_pkg.
module dth_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_value,
    output logic [31:0] o_root
);
    localparam int S = dth_pkg::SQ_STEPS;

    logic [63:0] r_v   [S];
    logic [63:0] r_res [S];

    for (genvar i = 0; i < S; i++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] v_in, res_in, trial, n_v, n_res;

        if (i == 0) begin : g_first
            assign v_in   = i_value;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[i-1];
            assign res_in = r_res[i-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (v_in >= trial) begin
                n_v   = v_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = v_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[i]   <= n_v;
                r_res[i] <= n_res;
            end
        end
    end

    assign o_root = r_res[S-1][31:0];
endmodule

// ----- rtl/dth_vec.sv -----
// dth_vec: pipelined CORDIC vectoring, angle of (x, y) in 32-bit turn units.
// Normalize in five shift stages, fold to the right half plane, iterate. Uses dth_pkg.
module dth_vec (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic [31:0]        o_angle
);
    localparam int N  = dth_pkg::CORDIC_STEPS;
    localparam int NS = dth_pkg::NORM_STEPS;
    localparam int L  = dth_pkg::VEC_LAT;

    logic signed [33:0] r_nx [NS+1];
    logic signed [33:0] r_ny [NS+1];
    logic               r_zero [L];
    logic signed [35:0] r_cx [N+1];
    logic signed [35:0] r_cy [N+1];
    logic signed [33:0] r_cz [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0]   <= i_x;
            r_ny[0]   <= i_y;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar k = 1; k < L; k++) begin : g_zero
        always_ff @(posedge i_clk) begin
            if (i_en) r_zero[k] <= r_zero[k-1];
        end
    end

    // greedy shift by 16, 8, 4, 2, 1 until one magnitude reaches 2^29;
    // the last doubling may carry a magnitude up to just under 2^30
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 16 >> j;
        localparam logic [33:0] LIM = 34'd1 << (30 - SH);
        logic [33:0] mx, my;

        always_comb begin
            mx = r_nx[j][33] ? 34'(-r_nx[j]) : 34'(r_nx[j]);
            my = r_ny[j][33] ? 34'(-r_ny[j]) : 34'(r_ny[j]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (mx < LIM && my < LIM) begin
                    r_nx[j+1] <= r_nx[j] <<< SH;
                    r_ny[j+1] <= r_ny[j] <<< SH;
                end else begin
                    r_nx[j+1] <= r_nx[j];
                    r_ny[j+1] <= r_ny[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_nx[NS] < 0) begin
                r_cx[0] <= -36'(r_nx[NS]);
                r_cy[0] <= -36'(r_ny[NS]);
                r_cz[0] <= 34'sh0_8000_0000;
            end else begin
                r_cx[0] <= 36'(r_nx[NS]);
                r_cy[0] <= 36'(r_ny[NS]);
                r_cz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + $signed({2'b00, dth_pkg::ATAN_TAB[i]});
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - $signed({2'b00, dth_pkg::ATAN_TAB[i]});
                end
            end
        end
    end

    assign o_angle = r_zero[L-1] ? 32'd0 : r_cz[N][31:0];
endmodule

// ----- rtl/dubins_tangent_heading.sv -----
// dubins_tangent_heading: top level; heading from the first tangent point to
// the target. Uses dth_pkg, dth_sincos, dth_isqrt, dth_vec.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+----------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_start_x/y, i_start_heading, i_target_x/y
//  out     | o_out_valid | i_out_stall | o_reachable, o_target_heading
//  cfg     | i_cfg_we    | -           | i_cfg_data (turn radius)
//
// One transaction per cycle while the pipeline is not held. Register stages in order:
// input, sine/cosine CORDIC, products, offset, scaling, squares, inside test,
// square root, vectoring CORDIC and output; the depth is set by the two CORDIC
// chains and the one-bit-per-stage square root. The whole pipeline advances together;
// it holds only while the output register is full and stalled. Synchronous reset
// clears the valid bits and loads the default radius.
module dubins_tangent_heading (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [15:0] i_start_heading,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_reachable,
    output logic signed [15:0] o_target_heading,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data
);
    localparam int SCL = dth_pkg::SC_LAT;
    localparam int SQL = dth_pkg::SQ_STEPS;
    localparam int VL  = dth_pkg::VEC_LAT;

    logic en;
    logic [30:0] r_turn_radius;

    dth_pkg::t_sc_side  r_s0;
    dth_pkg::t_sc_side  r_scd [SCL];
    dth_pkg::t_sc_side  r_s1;
    logic signed [64:0] r_p1, r_p2;
    logic signed [63:0] r_qs, r_qc;

    logic               r_s2_valid, r_s2_right, r_s2_left;
    logic [15:0]        r_s2_th;
    logic signed [34:0] r_px, r_py;

    dth_pkg::t_sq_side  r_s3, r_s4, r_s5;
    dth_pkg::t_sq_side  r_sqd [SQL];
    logic [63:0]        r_mx2, r_my2, r_rr, r_diff;

    dth_pkg::t_vec_side r_vd [VL];

    logic               r_out_valid, r_reachable;
    logic [15:0]        r_heading;

    logic signed [31:0] cos_v, sin_v;
    logic [31:0]        slen, phi_raw, angp;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_reachable = r_reachable;
    assign o_target_heading = r_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_radius <= dth_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_turn_radius <= i_cfg_data;
        end
    end

    // stage 0: start-to-target vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0.valid <= i_in_valid;
        end
        if (en) begin
            r_s0.dx <= 33'(i_target_x) - 33'(i_start_x);
            r_s0.dy <= 33'(i_target_y) - 33'(i_start_y);
            r_s0.th <= i_start_heading;
        end
    end

    dth_sincos u_sincos (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_heading (r_s0.th),
        .o_cos     (cos_v),
        .o_sin     (sin_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SCL; j++) r_scd[j] <= '0;
        end else if (en) begin
            r_scd[0] <= r_s0;
            for (int j = 1; j < SCL; j++) r_scd[j] <= r_scd[j-1];
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (en) begin
            r_s1.valid <= r_scd[SCL-1].valid;
        end
        if (en) begin
            r_s1.dx <= r_scd[SCL-1].dx;
            r_s1.dy <= r_scd[SCL-1].dy;
            r_s1.th <= r_scd[SCL-1].th;
            r_p1    <= 65'(r_scd[SCL-1].dy) * 65'(cos_v);
            r_p2    <= 65'(r_scd[SCL-1].dx) * 65'(sin_v);
            r_qs    <= 64'($signed({1'b0, r_turn_radius})) * 64'(sin_v);
            r_qc    <= 64'($signed({1'b0, r_turn_radius})) * 64'(cos_v);
        end
    end

    // stage 2: side of heading, circle offset, centre-to-target vector
    logic signed [64:0] cross_v;
    logic signed [63:0] qs_r, qc_r;
    logic signed [33:0] ox, oy;
    logic               n_right;

    always_comb begin
        cross_v = r_p1 - r_p2;
        qs_r    = r_qs + 64'sh2000_0000;
        qc_r    = r_qc + 64'sh2000_0000;
        ox      = qs_r[63:30];
        oy      = qc_r[63:30];
        n_right = cross_v < 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1.valid;
        end
        if (en) begin
            r_s2_right <= n_right;
            r_s2_left  <= cross_v > 0;
            r_s2_th    <= r_s1.th;
            if (n_right) begin
                r_px <= 35'(r_s1.dx) - 35'(ox);
                r_py <= 35'(r_s1.dy) + 35'(oy);
            end else begin
                r_px <= 35'(r_s1.dx) + 35'(ox);
                r_py <= 35'(r_s1.dy) - 35'(oy);
            end
        end
    end

    // stage 3: scale down until both components fit 31 bits
    dth_pkg::t_sq_side n_s3;
    logic signed [34:0] sx_k, sy_k;
    logic               found;

    always_comb begin
        n_s3       = '0;
        n_s3.valid = r_s2_valid;
        n_s3.right = r_s2_right;
        n_s3.left  = r_s2_left;
        n_s3.th    = r_s2_th;
        found      = 1'b0;
        n_s3.pxk   = 33'(r_px >>> 3);
        n_s3.pyk   = 33'(r_py >>> 3);
        n_s3.rk    = r_turn_radius >> 3;
        for (int k = 0; k < 4; k++) begin
            sx_k = r_px >>> k;
            sy_k = r_py >>> k;
            if (!found && sx_k > -35'sh0_8000_0000 && sx_k < 35'sh0_8000_0000 &&
                sy_k > -35'sh0_8000_0000 && sy_k < 35'sh0_8000_0000) begin
                found    = 1'b1;
                n_s3.pxk = 33'(sx_k);
                n_s3.pyk = 33'(sy_k);
                n_s3.rk  = r_turn_radius >> k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else if (en) begin
            r_s3 <= n_s3;
        end
    end

    // stage 4: squares
    logic [31:0] mx, my;

    always_comb begin
        mx = r_s3.pxk[32] ? 32'(-r_s3.pxk) : r_s3.pxk[31:0];
        my = r_s3.pyk[32] ? 32'(-r_s3.pyk) : r_s3.pyk[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
        end else if (en) begin
            r_s4 <= r_s3;
        end
        if (en) begin
            r_mx2 <= 64'(mx) * 64'(mx);
            r_my2 <= 64'(my) * 64'(my);
            r_rr  <= 64'(r_s3.rk) * 64'(r_s3.rk);
        end
    end

    // stage 5: inside test and tangent length squared
    logic [63:0] d2;
    dth_pkg::t_sq_side n_s5;
    assign d2 = r_mx2 + r_my2;

    always_comb begin
        n_s5       = r_s4;
        n_s5.reach = d2 >= r_rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5 <= '0;
        end else if (en) begin
            r_s5 <= n_s5;
        end
        if (en) r_diff <= d2 - r_rr;
    end

    dth_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_diff),
        .o_root  (slen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQL; j++) r_sqd[j] <= '0;
        end else if (en) begin
            r_sqd[0] <= r_s5;
            for (int j = 1; j < SQL; j++) r_sqd[j] <= r_sqd[j-1];
        end
    end

    dth_vec u_vec_phi (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     ({2'b00, slen}),
        .i_y     ({3'b000, r_sqd[SQL-1].rk}),
        .o_angle (phi_raw)
    );

    dth_vec u_vec_p (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (34'(r_sqd[SQL-1].pxk)),
        .i_y     (34'(r_sqd[SQL-1].pyk)),
        .o_angle (angp)
    );

    dth_pkg::t_vec_side n_vs;

    always_comb begin
        n_vs.valid = r_sqd[SQL-1].valid;
        n_vs.reach = r_sqd[SQL-1].reach;
        n_vs.right = r_sqd[SQL-1].right;
        n_vs.left  = r_sqd[SQL-1].left;
        n_vs.th    = r_sqd[SQL-1].th;
        n_vs.szero = slen == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VL; j++) r_vd[j] <= '0;
        end else if (en) begin
            r_vd[0] <= n_vs;
            for (int j = 1; j < VL; j++) r_vd[j] <= r_vd[j-1];
        end
    end

    // final: choose the tangent point met first along the turn
    dth_pkg::t_vec_side vt;
    logic [31:0] phi, th32, vs, a, b, offa, offb, h, hr;
    logic        pick_a;

    always_comb begin
        vt     = r_vd[VL-1];
        phi    = vt.szero ? dth_pkg::QTURN : phi_raw;
        th32   = {vt.th, 16'h0000};
        vs     = vt.right ? th32 + dth_pkg::QTURN : th32 - dth_pkg::QTURN;
        a      = angp + dth_pkg::QTURN - phi;
        b      = angp - dth_pkg::QTURN + phi;
        offa   = a - vs;
        offb   = b - vs;
        pick_a = vt.left ? (offa < offb) : (offa >= offb);
        h      = pick_a ? angp - phi : angp + phi;
        hr     = h + 32'h0000_8000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vt.valid;
        end
        if (en) begin
            r_reachable <= vt.reach;
            r_heading   <= vt.reach ? hr[31:16] : 16'h0000;
        end
    end
endmodule

// ----- sim/dth_checker.sv -----
`timescale 1ns / 100ps
// dth_checker: watches the input, output and radius ports of the tangent-heading
// block, predicts each result and compares. Depends on dth_pkg.
module dth_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [15:0] i_start_heading,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_reachable,
    input  logic signed [15:0] i_target_heading,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam longint QT = 64'sd1 <<< 30;

    typedef struct packed {
        logic        reach;
        logic [15:0] heading;
    } t_heading_result;

    // expected results in order; far deeper than the pipeline can hold
    t_heading_result heading_mem [256];
    int              n_pushed = 0;
    int              n_popped = 0;
    logic [30:0]     radius;
    int              mismatches = 0;

    function automatic int n_steps();
        return (dth_pkg::CORDIC_STEPS > 32) ? 32 : dth_pkg::CORDIC_STEPS;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void heading_sincos(input longint z_in, output longint c,
                                           output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        x = longint'(dth_pkg::CORDIC_K);
        y = 0;
        z = z_in;
        flip = 0;
        if (z > QT) begin
            z = z - 2 * QT;
            flip = 1;
        end else if (z < -QT) begin
            z = z + 2 * QT;
            flip = 1;
        end
        for (int i = 0; i < n_steps(); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(dth_pkg::ATAN_TAB[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(dth_pkg::ATAN_TAB[i]);
            end
        end
        if (x > QT) x = QT;
        if (x < -QT) x = -QT;
        if (y > QT) y = QT;
        if (y < -QT) y = -QT;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] angle_of(input longint x_in, input longint y_in);
        longint x, y, z, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;
        while (mag(x) < (64'sd1 <<< 29) && mag(y) < (64'sd1 <<< 29)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd1 <<< 31;
        end
        for (int i = 0; i < n_steps(); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(dth_pkg::ATAN_TAB[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(dth_pkg::ATAN_TAB[i]);
            end
        end
        return z[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, res, b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_heading_result predict_heading(
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [15:0] th, input logic signed [31:0] tx,
        input logic signed [31:0] ty, input logic [30:0] rad);
        t_heading_result res;
        longint r, c, s, dx, dy, cross_v, ox, oy, px, py, pxk, pyk, rk;
        longint unsigned d2, r2, slen;
        logic [31:0] phi, angp, th32, vs, a, b, offa, offb, h, hr;
        bit right, left_dir, pick_a;
        r = longint'(rad);
        heading_sincos(longint'(th) * 65536, c, s);
        dx = longint'(tx) - longint'(sx);
        dy = longint'(ty) - longint'(sy);
        cross_v = dy * c - dx * s;
        ox = (r * s + (64'sd1 <<< 29)) >>> 30;
        oy = (r * c + (64'sd1 <<< 29)) >>> 30;
        right = cross_v < 0;
        left_dir = cross_v > 0;
        if (right) begin
            px = dx - ox; py = dy + oy;
        end else begin
            px = dx + ox; py = dy - oy;
        end
        pxk = 0; pyk = 0; rk = 0;
        for (int k = 0; k < 4; k++) begin
            pxk = px >>> k;
            pyk = py >>> k;
            rk = r >>> k;
            if (mag(pxk) < (64'sd1 <<< 31) && mag(pyk) < (64'sd1 <<< 31) &&
                rk < (64'sd1 <<< 31))
                break;
        end
        d2 = longint'(mag(pxk)) * mag(pxk) + longint'(mag(pyk)) * mag(pyk);
        r2 = rk * rk;
        if (d2 < r2) begin
            res.reach = 0;
            res.heading = '0;
            return res;
        end
        slen = int_sqrt(d2 - r2);
        phi = (slen == 0) ? 32'h4000_0000 : angle_of(longint'(slen), rk);
        angp = angle_of(pxk, pyk);
        th32 = {th, 16'h0000};
        vs = right ? th32 + 32'h4000_0000 : th32 - 32'h4000_0000;
        a = angp + 32'h4000_0000 - phi;
        b = angp - 32'h4000_0000 + phi;
        offa = a - vs;
        offb = b - vs;
        pick_a = left_dir ? (offa < offb) : (offa >= offb);
        h = pick_a ? angp - phi : angp + phi;
        hr = h + 32'h0000_8000;
        res.reach = 1;
        res.heading = hr[31:16];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_heading_result want;
        if (!i_rst_n) begin
            radius <= dth_pkg::RADIUS_RESET;
        end else begin
            if (i_cfg_we) radius <= i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                heading_mem[n_pushed[7:0]] = predict_heading(i_start_x, i_start_y,
                    i_start_heading, i_target_x, i_target_y, radius);
                n_pushed++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (n_pushed == n_popped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: reach=%0d heading=%0d",
                                 i_reachable, i_target_heading);
                end else begin
                    want = heading_mem[n_popped[7:0]];
                    n_popped++;
                    if (want.reach !== i_reachable || want.heading !== i_target_heading) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: reach exp %0d got %0d, heading exp %0d got %0d",
                                     want.reach, i_reachable, $signed(want.heading),
                                     i_target_heading);
                    end
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_pending = n_pushed - n_popped;
endmodule

// ----- sim/dubins_tangent_heading_tb.sv -----
`timescale 1ns / 100ps
// dubins_tangent_heading_tb: stimulus and verdict for the tangent-heading block.
// Depends on dth_pkg, dubins_tangent_heading and dth_checker.
module dubins_tangent_heading_tb;
    localparam int DRAIN_CYCLES = 90;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] start_x = 0, start_y = 0, target_x = 0, target_y = 0;
    logic signed [15:0] start_heading = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic               reachable;
    logic signed [15:0] target_heading;
    logic               cfg_we = 0;
    logic [30:0]        cfg_data = 0;
    int                 fail_count, pending;
    bit                 calm = 0;
    int                 hold_reqs = 0;
    logic [30:0]        cur_radius = dth_pkg::RADIUS_RESET;

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    dubins_tangent_heading i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_start_x(start_x), .i_start_y(start_y), .i_start_heading(start_heading),
        .i_target_x(target_x), .i_target_y(target_y),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_reachable(reachable), .o_target_heading(target_heading),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    dth_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_start_x(start_x), .i_start_y(start_y), .i_start_heading(start_heading),
        .i_target_x(target_x), .i_target_y(target_y),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_reachable(reachable), .i_target_heading(target_heading),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall, long hold-off whenever one is requested
    always @(posedge clk) begin
        int hold_cnt;
        int hold_done;
        if (hold_done != hold_reqs) begin
            out_stall <= 1;
            hold_cnt++;
            if (hold_cnt >= 400) begin
                hold_done++;
                hold_cnt = 0;
            end
        end else begin
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
        end
    end

    task automatic send_pose(input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic signed [15:0] th, input logic signed [31:0] tx,
                             input logic signed [31:0] ty);
        logic st;
        while (!calm && $urandom_range(99) < 38) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        start_x <= sx; start_y <= sy; start_heading <= th;
        target_x <= tx; target_y <= ty;
        do begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end while (st);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_radius(input logic [30:0] v);
        drain();
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        cur_radius = v;
        @(posedge clk);
    endtask

    // mostly targets a few radii away from the start, some full range
    task automatic random_pose();
        logic signed [31:0] sx, sy, tx, ty;
        longint span;
        int kind;
        kind = $urandom_range(99);
        sx = $urandom; sy = $urandom;
        if (kind < 15) begin
            tx = $urandom; ty = $urandom;
        end else begin
            span = (cur_radius > 31'd100_000_000) ? 64'd100_000_000 :
                   longint'(cur_radius) * (kind < 50 ? 2 : 12) + 4;
            sx = $signed($urandom) >>> $urandom_range(10, 1);
            sy = $signed($urandom) >>> $urandom_range(10, 1);
            tx = sx + 32'($urandom_range(32'(2 * span)) - span);
            ty = sy + 32'($urandom_range(32'(2 * span)) - span);
        end
        send_pose(sx, sy, 16'($urandom), tx, ty);
    endtask

    initial begin
        logic [30:0] radii[5];
        int r;
        r = 98304;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // heading extremes, collinear target, target on and inside the circle
        send_pose(0, 0, 16'sh0000, 32'sh0005_0000, 0);
        send_pose(0, 0, 16'sh0000, 0, 0);
        send_pose(0, 0, 16'sh0000, 0, r);
        send_pose(0, 0, 16'sh0000, 0, -r);
        send_pose(0, 0, 16'sh4000, 0, 32'sh0003_0000);
        send_pose(0, 0, -16'sh8000, 32'sh0004_0000, 0);
        send_pose(0, 0, 16'sh7fff, 32'sh0002_0000, 32'sh0002_0000);
        send_pose(0, 0, -16'sh4000, 32'sh0002_0000, -32'sh0002_0000);
        send_pose(32'sh7fffffff, 32'sh7fffffff, 0, -32'sh80000000, -32'sh80000000);
        send_pose(-32'sh80000000, -32'sh80000000, 16'sh2000, 32'sh7fffffff, 32'sh7fffffff);
        send_pose(-32'sh80000000, 32'sh7fffffff, -16'sh6000, 32'sh7fffffff, -32'sh80000000);
        send_pose(32'sh7fffffff, 0, 16'sh1234, 32'sh7fffffff, 0);
        send_pose(0, 0, 0, 32'sh0000_8000, 32'sh0000_4000);
        send_pose(0, 0, 0, 32'sh0010_0000, -32'sh0000_1000);

        radii[0] = 31'd1;
        radii[1] = 31'h7fffffff;
        radii[2] = 31'd0;
        radii[3] = 31'd65536;
        radii[4] = 31'd300000;
        for (int ph = 0; ph < 5; ph++) begin
            set_radius(radii[ph]);
            send_pose(0, 0, 0, 0, 0);
            send_pose(0, 0, 16'sh4000, 32'sh7fffffff, -32'sh80000000);
            for (int n = 0; n < (ph >= 3 ? 500 : 180); n++) begin
                calm = (ph == 3 && n >= 100 && n < 200);
                if (ph == 4 && n == 50) hold_reqs++;
                if (ph == 3 && n == 300) drain();
                if (ph == 4 && n == 250) set_radius(31'($urandom_range(20000, 2000000)));
                random_pose();
            end
            calm = 0;
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
